/* rtl/core/occupancy_counter_with_lockout_assert.svh */
// assertion macros for the occupancy counter
`ifndef OCCUPANCY_COUNTER_WITH_LOCKOUT_ASSERT_SVH
`define OCCUPANCY_COUNTER_WITH_LOCKOUT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define OCC_ASSERT_NOW(label, clock, reset, cond, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define OCC_ASSERT_NEXT(label, clock, reset, cond, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* rtl/core/occ_pkg.sv */
// shared types and constants of the occupancy counter
package occ_pkg;

  // register indexes
  localparam logic [1:0] REG_NODE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_MOTION_HOLD  = 2'd1;
  localparam logic [1:0] REG_SWITCH_HOLD  = 2'd2;

  // register reset values
  localparam logic [7:0]  NODE_ADDRESS_RST = 8'h01;
  localparam logic [15:0] MOTION_HOLD_RST  = 16'd5050;
  localparam logic [15:0] SWITCH_HOLD_RST  = 16'd300;

  localparam logic [7:0]  SWITCH_IDLE = 8'hFF;
  localparam logic [15:0] HOLD_MAX    = 16'hFFFF;
  localparam logic [7:0]  COUNT_MAX   = 8'hFF;
  localparam logic [7:0]  COUNT_MIN   = 8'h00;

  // frame characters
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // payload slots of one report
  localparam logic [2:0] SLOT_ADDR  = 3'd0;
  localparam logic [2:0] SLOT_SW    = 3'd1;
  localparam logic [2:0] SLOT_COUNT = 3'd2;
  localparam logic [2:0] SLOT_LF    = 3'd3;
  localparam logic [2:0] SLOT_CR    = 3'd4;

  // byte positions within one frame
  localparam logic [2:0] FLD_START = 3'd0;
  localparam logic [2:0] FLD_MARK  = 3'd1;
  localparam logic [2:0] FLD_DATA  = 3'd2;
  localparam logic [2:0] FLD_INV   = 3'd3;
  localparam logic [2:0] FLD_END   = 3'd4;

  typedef struct packed {
    logic [7:0] node_address;
    logic [7:0] switch_byte;
    logic [7:0] people_count;
  } report_t;

  typedef struct packed {
    logic busy;
    logic finishing;
  } tx_status_t;

endpackage

/* rtl/core/occ_sample_if.sv */
// sample channel: one tick of sensor inputs per word
interface occ_sample_if;
  logic       valid;
  logic       ready;
  logic [7:0] switch_bits;
  logic       entry_motion;
  logic       exit_motion;

  modport source (output valid, output switch_bits, output entry_motion,
                  output exit_motion, input ready);
  modport sink   (input valid, input switch_bits, input entry_motion,
                  input exit_motion, output ready);
endinterface

/* rtl/core/occ_report_if.sv */
// report channel: one byte of the radio report per word
interface occ_report_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;

  modport source (output valid, output tx_byte, output last_byte, input ready);
  modport sink   (input valid, input tx_byte, input last_byte, output ready);
endinterface

/* rtl/core/occ_hold.sv */
// lockout timer for one event: hold counter and lock flag
module occ_hold (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick,
  input  logic        fire,
  input  logic [15:0] limit,
  output logic        locked
);

  logic [15:0] count;
  logic [15:0] count_base;
  logic [15:0] count_next;

  always_comb begin
    count_base = fire ? 16'd0 : count;
    if (count_base <= limit && count_base != occ_pkg::HOLD_MAX) begin
      count_next = count_base + 16'd1;
    end else begin
      count_next = count_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 16'd0;
      locked <= 1'b0;
    end else if (tick) begin
      count <= count_next;
      // a lock set this tick may clear at once when the limit is tiny
      locked <= (count_next > limit) ? 1'b0 : (locked | fire);
    end
  end

endmodule

/* rtl/core/occ_report_tx.sv */
// report serializer: five framed payloads, 25 bytes
module occ_report_tx (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  occ_pkg::report_t     payload_in,
  output occ_pkg::tx_status_t  status,
  occ_report_if.source         report
);

  logic             busy;
  logic [2:0]       slot;
  logic [2:0]       field;
  occ_pkg::report_t payload;
  logic [7:0]       data;
  logic             last;

  always_comb begin
    case (slot)
      occ_pkg::SLOT_ADDR:  data = payload.node_address;
      occ_pkg::SLOT_SW:    data = payload.switch_byte;
      occ_pkg::SLOT_COUNT: data = payload.people_count;
      occ_pkg::SLOT_LF:    data = occ_pkg::CH_LF;
      default:             data = occ_pkg::CH_CR;
    endcase
  end

  always_comb begin
    case (field)
      occ_pkg::FLD_START: report.tx_byte = occ_pkg::CH_AT;
      occ_pkg::FLD_MARK:  report.tx_byte = occ_pkg::CH_HASH;
      occ_pkg::FLD_DATA:  report.tx_byte = data;
      occ_pkg::FLD_INV:   report.tx_byte = ~data;
      default:            report.tx_byte = occ_pkg::CH_DOLLAR;
    endcase
  end

  assign last             = (slot == occ_pkg::SLOT_CR) && (field == occ_pkg::FLD_END);
  assign report.valid     = busy;
  assign report.last_byte = last;
  assign status.busy      = busy;
  assign status.finishing = busy && last && report.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      slot  <= occ_pkg::SLOT_ADDR;
      field <= occ_pkg::FLD_START;
    end else if (start) begin
      busy  <= 1'b1;
      slot  <= occ_pkg::SLOT_ADDR;
      field <= occ_pkg::FLD_START;
    end else if (busy && report.ready) begin
      if (field == occ_pkg::FLD_END) begin
        field <= occ_pkg::FLD_START;
        if (slot == occ_pkg::SLOT_CR) begin
          busy <= 1'b0;
        end else begin
          slot <= slot + 3'd1;
        end
      end else begin
        field <= field + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      payload <= payload_in;
    end
  end

endmodule

/* rtl/core/occupancy_counter_with_lockout.sv */
// occupancy counter with per-event lockout and framed report, top level
// a tick word updates locks, hold counters and the people count in the cycle it is taken
// ticks with no event are taken, a new one every cycle, while no report drains
// a tick with an event starts a 25-byte report, first byte valid the next cycle
// a report drains one byte per cycle while the receiver is ready; ticks are taken only with its last byte
// synchronous reset clears locks, counters and count, and loads register defaults
module occupancy_counter_with_lockout (
  input  logic        clk,
  input  logic        rst,
  occ_sample_if.sink  samples,
  occ_report_if.source report,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "occupancy_counter_with_lockout_assert.svh"

  logic [7:0]  node_address;
  logic [15:0] motion_hold_ticks;
  logic [15:0] switch_hold_ticks;

  logic [7:0]  last_switch_byte;
  logic [7:0]  last_switch_byte_next;
  logic [7:0]  people_count;
  logic [7:0]  people_count_next;
  logic [7:0]  count_mid;

  logic switch_locked;
  logic entry_locked;
  logic exit_locked;
  logic tick;
  logic switch_fire;
  logic entry_fire;
  logic exit_fire;
  logic any_fire;

  occ_pkg::tx_status_t tx_status;
  occ_pkg::report_t    report_payload;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address      <= occ_pkg::NODE_ADDRESS_RST;
      motion_hold_ticks <= occ_pkg::MOTION_HOLD_RST;
      switch_hold_ticks <= occ_pkg::SWITCH_HOLD_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        occ_pkg::REG_NODE_ADDRESS: node_address      <= pwdata[7:0];
        occ_pkg::REG_MOTION_HOLD:  motion_hold_ticks <= pwdata[15:0];
        occ_pkg::REG_SWITCH_HOLD:  switch_hold_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      occ_pkg::REG_NODE_ADDRESS: prdata = {24'd0, node_address};
      occ_pkg::REG_MOTION_HOLD:  prdata = {16'd0, motion_hold_ticks};
      occ_pkg::REG_SWITCH_HOLD:  prdata = {16'd0, switch_hold_ticks};
      default:                   prdata = 32'd0;
    endcase
  end

  // tick word handling
  assign samples.ready = !tx_status.busy || tx_status.finishing;
  assign tick          = samples.valid && samples.ready;

  assign switch_fire = tick && (samples.switch_bits != occ_pkg::SWITCH_IDLE) && !switch_locked;
  assign entry_fire  = tick && samples.entry_motion && !entry_locked;
  assign exit_fire   = tick && samples.exit_motion && !exit_locked;
  assign any_fire    = switch_fire || entry_fire || exit_fire;

  always_comb begin
    last_switch_byte_next = switch_fire ? samples.switch_bits : last_switch_byte;
    // entry is applied before exit
    count_mid = people_count;
    if (entry_fire && people_count != occ_pkg::COUNT_MAX) begin
      count_mid = people_count + 8'd1;
    end
    people_count_next = count_mid;
    if (exit_fire && count_mid != occ_pkg::COUNT_MIN) begin
      people_count_next = count_mid - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_switch_byte <= 8'd0;
      people_count     <= 8'd0;
    end else begin
      last_switch_byte <= last_switch_byte_next;
      people_count     <= people_count_next;
    end
  end

  occ_hold u_switch_hold (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick),
    .fire   (switch_fire),
    .limit  (switch_hold_ticks),
    .locked (switch_locked)
  );

  occ_hold u_entry_hold (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick),
    .fire   (entry_fire),
    .limit  (motion_hold_ticks),
    .locked (entry_locked)
  );

  occ_hold u_exit_hold (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick),
    .fire   (exit_fire),
    .limit  (motion_hold_ticks),
    .locked (exit_locked)
  );

  assign report_payload.node_address = node_address;
  assign report_payload.switch_byte  = last_switch_byte_next;
  assign report_payload.people_count = people_count_next;

  occ_report_tx u_report_tx (
    .clk        (clk),
    .rst        (rst),
    .start      (any_fire),
    .payload_in (report_payload),
    .status     (tx_status),
    .report     (report)
  );

  // a tick is taken during a report only together with its last word
  `OCC_ASSERT_NOW(a_tick_only_at_report_end, clk, rst, samples.valid && samples.ready && report.valid, report.last_byte && report.ready, "tick taken mid-report")

  // an event starts a report at its first frame byte
  `OCC_ASSERT_NEXT(a_event_starts_report, clk, rst, tick && any_fire, report.valid && report.tx_byte == occ_pkg::CH_AT, "event did not start a report")

  // the report ends after its last word unless a new event restarts it
  `OCC_ASSERT_NEXT(a_report_ends, clk, rst, report.valid && report.ready && report.last_byte && !any_fire, !report.valid, "report ran past its last word")

endmodule

/* sim/occupancy_counter_with_lockout_tb.sv */
// testbench for the occupancy counter: directed ticks, then random phases checked by a predictor
`timescale 1ns / 1ps

module occupancy_counter_with_lockout_tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_OFF_AT = 900;
  localparam int HOLD_OFF_CYCLES = 300;

  // hold counter slots
  localparam int HOLD_SW = 0;
  localparam int HOLD_ENTRY = 1;
  localparam int HOLD_EXIT = 2;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_REPORT} check_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [1:0]       reg_idx;
    logic [15:0]      value;
    logic [7:0]       sw;
    logic             en;
    logic             ex;
    check_t           chk;
    occ_pkg::report_t typed;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } report_word_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  occ_sample_if samples_bus ();
  occ_report_if report_bus ();

  occupancy_counter_with_lockout u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_bus),
    .report  (report_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [7:0]  cfg_node;
  logic [15:0] cfg_motion_hold;
  logic [15:0] cfg_switch_hold;
  logic [2:0]  lock_flags;
  logic [15:0] hold_cnt [3];
  logic [7:0]  last_sw;
  logic [7:0]  people;

  report_word_t pending_bytes [$];
  report_word_t due_word;
  int mismatches;
  int bytes_seen;
  int quiet_cycles;
  int sender_steady;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit step_occupancy(input logic [7:0] sw, input logic en, input logic ex,
                                        output occ_pkg::report_t rep);
    logic [15:0] lim [3];
    bit fired;
    fired = 1'b0;
    if (sw != occ_pkg::SWITCH_IDLE && !lock_flags[HOLD_SW]) begin
      lock_flags[HOLD_SW] = 1'b1;
      hold_cnt[HOLD_SW] = '0;
      last_sw = sw;
      fired = 1'b1;
    end
    if (en && !lock_flags[HOLD_ENTRY]) begin
      lock_flags[HOLD_ENTRY] = 1'b1;
      hold_cnt[HOLD_ENTRY] = '0;
      if (people != occ_pkg::COUNT_MAX) people = people + 8'd1;
      fired = 1'b1;
    end
    if (ex && !lock_flags[HOLD_EXIT]) begin
      lock_flags[HOLD_EXIT] = 1'b1;
      hold_cnt[HOLD_EXIT] = '0;
      if (people != occ_pkg::COUNT_MIN) people = people - 8'd1;
      fired = 1'b1;
    end
    lim[HOLD_SW] = cfg_switch_hold;
    lim[HOLD_ENTRY] = cfg_motion_hold;
    lim[HOLD_EXIT] = cfg_motion_hold;
    // counters stop one past their limit, or at full scale, and never wrap
    for (int i = 0; i < 3; i++) begin
      if (hold_cnt[i] <= lim[i] && hold_cnt[i] != occ_pkg::HOLD_MAX) begin
        hold_cnt[i] = hold_cnt[i] + 16'd1;
      end
      if (hold_cnt[i] > lim[i]) lock_flags[i] = 1'b0;
    end
    rep = '{cfg_node, last_sw, people};
    return fired;
  endfunction

  function automatic void queue_report(input occ_pkg::report_t rep);
    logic [7:0] data [5];
    logic [7:0] frame [5];
    data = '{rep.node_address, rep.switch_byte, rep.people_count, occ_pkg::CH_LF,
             occ_pkg::CH_CR};
    for (int p = 0; p < 5; p++) begin
      frame = '{occ_pkg::CH_AT, occ_pkg::CH_HASH, data[p], ~data[p], occ_pkg::CH_DOLLAR};
      for (int f = 0; f < 5; f++) pending_bytes.push_back('{frame[f], (p == 4 && f == 4)});
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(3, 1);
    if (r < 92) return $urandom_range(8, 4);
    return $urandom_range(40, 12);
  endfunction

  function automatic int sender_gap();
    int r;
    if (sender_steady > 0) begin
      sender_steady--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 6) begin
      sender_steady = $urandom_range(60, 20);
      return 0;
    end
    if (r < 50) return 0;
    return pick_gap();
  endfunction

  function automatic dir_row_t tick_row(input logic [7:0] sw, input logic en, input logic ex,
                                        input check_t chk, input occ_pkg::report_t typed);
    return '{ROW_TICK, occ_pkg::REG_NODE_ADDRESS, 16'd0, sw, en, ex, chk, typed};
  endfunction

  function automatic dir_row_t cfg_row(input logic [1:0] idx, input logic [15:0] value);
    return '{ROW_CFG, idx, value, occ_pkg::SWITCH_IDLE, 1'b0, 1'b0, CHK_NONE,
             occ_pkg::report_t'(0)};
  endfunction

  task automatic send_tick(input logic [7:0] sw, input logic en, input logic ex,
                           input check_t chk, input occ_pkg::report_t typed);
    int gap;
    occ_pkg::report_t rep;
    bit fired;
    gap = sender_gap();
    repeat (gap) begin
      @(negedge clk);
      samples_bus.valid = 1'b0;
    end
    @(negedge clk);
    samples_bus.valid = 1'b1;
    samples_bus.switch_bits = sw;
    samples_bus.entry_motion = en;
    samples_bus.exit_motion = ex;
    do @(posedge clk); while (samples_bus.ready !== 1'b1);
    fired = step_occupancy(sw, en, ex, rep);
    case (chk)
      CHK_MODEL:  if (fired) queue_report(rep);
      CHK_REPORT: queue_report(typed);
      default: ;
    endcase
  endtask

  // drop valid and let every pending report drain before touching registers
  task automatic quiesce();
    @(negedge clk);
    samples_bus.valid = 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      occ_pkg::REG_NODE_ADDRESS: cfg_node = value[7:0];
      occ_pkg::REG_MOTION_HOLD:  cfg_motion_hold = value;
      occ_pkg::REG_SWITCH_HOLD:  cfg_switch_hold = value;
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] motion, input logic [15:0] sw_hold, input int ticks,
                           input int en_pct, input int ex_pct, input int press_pct);
    logic [7:0] sw;
    quiesce();
    apb_write(occ_pkg::REG_NODE_ADDRESS, 16'($urandom_range(255)));
    apb_write(occ_pkg::REG_MOTION_HOLD, motion);
    apb_write(occ_pkg::REG_SWITCH_HOLD, sw_hold);
    repeat (ticks) begin
      sw = ($urandom_range(99) < press_pct) ? 8'($urandom_range(255)) : occ_pkg::SWITCH_IDLE;
      send_tick(sw, $urandom_range(99) < en_pct, $urandom_range(99) < ex_pct, CHK_MODEL,
                occ_pkg::report_t'(0));
    end
  endtask

  // report drain side, with one long hold-off so the block backs up
  initial begin : report_drain
    int stall_left;
    int steady_left;
    bit held;
    int r;
    stall_left = 0;
    steady_left = 0;
    held = 1'b0;
    report_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && bytes_seen >= HOLD_OFF_AT) begin
        held = 1'b1;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        report_bus.ready = 1'b0;
        stall_left--;
      end else if (steady_left > 0) begin
        report_bus.ready = 1'b1;
        steady_left--;
      end else begin
        report_bus.ready = 1'b1;
        r = $urandom_range(99);
        if (r < 8) steady_left = $urandom_range(80, 30);
        else if (r < 30) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && report_bus.valid === 1'b1 && report_bus.ready === 1'b1) begin
      bytes_seen++;
      if (pending_bytes.size() == 0) begin
        $display("%0t: report word %h last %b with nothing expected", $time,
                 report_bus.tx_byte, report_bus.last_byte);
        mismatches++;
      end else begin
        due_word = pending_bytes.pop_front();
        if (report_bus.tx_byte !== due_word.tx_byte) begin
          $display("%0t: tx_byte expected %h got %h", $time, due_word.tx_byte,
                   report_bus.tx_byte);
          mismatches++;
        end
        if (report_bus.last_byte !== due_word.last_byte) begin
          $display("%0t: last_byte expected %b got %b", $time, due_word.last_byte,
                   report_bus.last_byte);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles where no word and no register write moves
  always @(posedge clk) begin
    if ((samples_bus.valid === 1'b1 && samples_bus.ready === 1'b1) ||
        (report_bus.valid === 1'b1 && report_bus.ready === 1'b1) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : main_seq
    dir_row_t rows [$];
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    samples_bus.valid = 1'b0;
    samples_bus.switch_bits = occ_pkg::SWITCH_IDLE;
    samples_bus.entry_motion = 1'b0;
    samples_bus.exit_motion = 1'b0;
    mismatches = 0;
    bytes_seen = 0;
    quiet_cycles = 0;
    sender_steady = 0;

    cfg_node = occ_pkg::NODE_ADDRESS_RST;
    cfg_motion_hold = occ_pkg::MOTION_HOLD_RST;
    cfg_switch_hold = occ_pkg::SWITCH_HOLD_RST;
    lock_flags = '0;
    hold_cnt = '{16'd0, 16'd0, 16'd0};
    last_sw = '0;
    people = '0;

    // register defaults after reset
    rows.push_back(tick_row(8'hFF, 1'b0, 1'b0, CHK_NONE, occ_pkg::report_t'(0)));
    rows.push_back(tick_row(8'h00, 1'b1, 1'b0, CHK_REPORT, '{8'h01, 8'h00, 8'h01}));
    rows.push_back(tick_row(8'h7E, 1'b1, 1'b0, CHK_NONE, occ_pkg::report_t'(0)));
    // limits dropped below running counters, then zero-tick lockout
    rows.push_back(cfg_row(occ_pkg::REG_MOTION_HOLD, 16'd0));
    rows.push_back(cfg_row(occ_pkg::REG_SWITCH_HOLD, 16'd0));
    rows.push_back(tick_row(8'hFF, 1'b1, 1'b0, CHK_NONE, occ_pkg::report_t'(0)));
    rows.push_back(tick_row(8'hFF, 1'b0, 1'b1, CHK_REPORT, '{8'h01, 8'h00, 8'h00}));
    // exit at an empty count stays at zero
    rows.push_back(tick_row(8'hFF, 1'b0, 1'b1, CHK_REPORT, '{8'h01, 8'h00, 8'h00}));
    rows.push_back(tick_row(8'h5A, 1'b0, 1'b0, CHK_REPORT, '{8'h01, 8'h5A, 8'h00}));
    // full-scale limits never release
    rows.push_back(cfg_row(occ_pkg::REG_NODE_ADDRESS, 16'h00FF));
    rows.push_back(cfg_row(occ_pkg::REG_SWITCH_HOLD, occ_pkg::HOLD_MAX));
    rows.push_back(cfg_row(occ_pkg::REG_MOTION_HOLD, occ_pkg::HOLD_MAX));
    rows.push_back(tick_row(8'hA5, 1'b1, 1'b0, CHK_REPORT, '{8'hFF, 8'hA5, 8'h01}));
    rows.push_back(tick_row(8'h00, 1'b1, 1'b1, CHK_MODEL, occ_pkg::report_t'(0)));
    rows.push_back(tick_row(8'h00, 1'b1, 1'b1, CHK_MODEL, occ_pkg::report_t'(0)));
    rows.push_back(tick_row(8'h00, 1'b0, 1'b0, CHK_MODEL, occ_pkg::report_t'(0)));
    rows.push_back(cfg_row(occ_pkg::REG_SWITCH_HOLD, 16'd1));
    rows.push_back(cfg_row(occ_pkg::REG_NODE_ADDRESS, 16'h0000));
    rows.push_back(cfg_row(occ_pkg::REG_MOTION_HOLD, 16'd1));
    rows.push_back(tick_row(8'hFE, 1'b0, 1'b0, CHK_MODEL, occ_pkg::report_t'(0)));
    rows.push_back(tick_row(8'h7F, 1'b1, 1'b0, CHK_MODEL, occ_pkg::report_t'(0)));
    rows.push_back(tick_row(8'hFF, 1'b1, 1'b0, CHK_MODEL, occ_pkg::report_t'(0)));
    rows.push_back(tick_row(8'hFF, 1'b1, 1'b0, CHK_MODEL, occ_pkg::report_t'(0)));
    rows.push_back(tick_row(8'h80, 1'b0, 1'b1, CHK_MODEL, occ_pkg::report_t'(0)));
    rows.push_back(tick_row(8'h01, 1'b1, 1'b1, CHK_MODEL, occ_pkg::report_t'(0)));
    rows.push_back(tick_row(8'hFF, 1'b1, 1'b1, CHK_MODEL, occ_pkg::report_t'(0)));
    rows.push_back(tick_row(8'hFF, 1'b0, 1'b0, CHK_MODEL, occ_pkg::report_t'(0)));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[k]) begin
      if (rows[k].kind == ROW_CFG) begin
        quiesce();
        apb_write(rows[k].reg_idx, rows[k].value);
      end else begin
        send_tick(rows[k].sw, rows[k].en, rows[k].ex, rows[k].chk, rows[k].typed);
      end
    end

    run_phase(16'd2, 16'd3, 30, 50, 40, 30);
    // every entry fires, so each tick starts a report
    run_phase(16'd0, 16'd0, 120, 100, 0, 40);
    run_phase(16'd65534, 16'd65534, 8, 50, 50, 50);
    run_phase(16'd1, 16'd1, 30, 25, 75, 30);
    run_phase(16'($urandom_range(6)), 16'($urandom_range(6)), 25, 40, 40, 20);

    quiesce();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* occupancy_counter_with_lockout.f */
+incdir+rtl/core
rtl/core/occ_pkg.sv
rtl/core/occ_sample_if.sv
rtl/core/occ_report_if.sv
rtl/core/occ_hold.sv
rtl/core/occ_report_tx.sv
rtl/core/occupancy_counter_with_lockout.sv
sim/occupancy_counter_with_lockout_tb.sv
